// ----- rtl/sid_pkg.sv -----
`default_nettype none

package sid_pkg;

    localparam int unsigned W               = 32;
    localparam int unsigned STEPS_PER_STAGE = 2;
    localparam int unsigned NUM_STAGES      = W / STEPS_PER_STAGE;

    localparam logic [W-1:0] POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [W-1:0] NEG_NEAR = 32'h8000_0001;  // -2147483647, zero divisor, neg dividend

    typedef struct packed {
        logic         q_neg;   // operand signs differ
        logic         div0;
        logic         a_neg;
        logic         a_zero;
        logic [W-1:0] rem;     // partial remainder
        logic [W-1:0] dvd;     // dividend bits still to shift out, quotient bits shifted in
        logic [W-1:0] dvs;     // divisor magnitude
    } t_div_state;

    // one restoring division step: one quotient bit
    function automatic t_div_state div_step(input t_div_state s);
        logic [W:0]  trial;
        logic [W:0]  diff;
        t_div_state  r;
        r     = s;
        trial = {s.rem, s.dvd[W-1]};
        diff  = trial - {1'b0, s.dvs};
        r.dvd = {s.dvd[W-2:0], ~diff[W]};
        r.rem = diff[W] ? trial[W-1:0] : diff[W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/signed_int32_divider.sv -----
// Pipelined signed 32-bit divider, truncating toward zero.
// An accepted item passes the operand prep stage, 16 stages of two restoring steps each
// and the output register before o_valid rises.
// Throughput: one item per cycle while busy is low; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) drops every item in flight; busy is high during reset
// and for the first cycle after it.
`default_nettype none

module signed_int32_divider (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic signed [31:0]     i_numerator,
    input  wire logic signed [31:0]     i_denominator,
    output logic                        o_valid,
    output logic signed [31:0]          o_quotient
);

    localparam int unsigned W  = sid_pkg::W;
    localparam int unsigned NS = sid_pkg::NUM_STAGES;

    logic                r_busy;
    logic                accept;

    logic                r_pre_vld;
    sid_pkg::t_div_state r_pre;
    sid_pkg::t_div_state n_pre;

    logic                r_stg_vld [NS];
    sid_pkg::t_div_state r_stg     [NS];
    sid_pkg::t_div_state n_stg     [NS];

    logic                r_out_vld;
    logic [W-1:0]        r_quot;
    logic [W-1:0]        n_quot;

    assign busy   = r_busy | ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        r_busy <= ~i_rst_n;
    end

    // operand prep: magnitudes and the special-case flags
    always_comb begin
        logic [W-1:0] a;
        logic [W-1:0] b;
        a            = i_numerator;
        b            = i_denominator;
        n_pre.a_neg  = a[W-1];
        n_pre.q_neg  = a[W-1] ^ b[W-1];
        n_pre.div0   = (b == '0);
        n_pre.a_zero = (a == '0);
        n_pre.rem    = '0;
        n_pre.dvd    = a[W-1] ? (~a + 1'b1) : a;
        n_pre.dvs    = b[W-1] ? (~b + 1'b1) : b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_vld <= 1'b0;
        end else begin
            r_pre_vld <= accept;
        end
        r_pre <= n_pre;
    end

    for (genvar g = 0; g < NS; g++) begin : g_stage
        always_comb begin
            sid_pkg::t_div_state s;
            s = (g == 0) ? r_pre : r_stg[(g == 0) ? 0 : g-1];
            for (int k = 0; k < sid_pkg::STEPS_PER_STAGE; k++) begin
                s = sid_pkg::div_step(s);
            end
            n_stg[g] = s;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg_vld[g] <= 1'b0;
            end else begin
                r_stg_vld[g] <= (g == 0) ? r_pre_vld : r_stg_vld[(g == 0) ? 0 : g-1];
            end
            r_stg[g] <= n_stg[g];
        end
    end

    // sign fix-up, saturation and the zero-divisor answers
    always_comb begin
        sid_pkg::t_div_state f;
        f = r_stg[NS-1];
        if (f.div0) begin
            if (f.a_zero) begin
                n_quot = '0;
            end else if (f.a_neg) begin
                n_quot = sid_pkg::NEG_NEAR;
            end else begin
                n_quot = sid_pkg::POS_MAX;
            end
        end else if (f.q_neg) begin
            n_quot = ~f.dvd + 1'b1;
        end else if (f.dvd[W-1]) begin
            n_quot = sid_pkg::POS_MAX;   // minimum value divided by minus one
        end else begin
            n_quot = f.dvd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_stg_vld[NS-1];
        end
        r_quot <= n_quot;
    end

    assign o_valid    = r_out_vld;
    assign o_quotient = r_quot;

    a_busy_low_after_reset: assert property (@(posedge i_clk)
        $past(i_rst_n) && i_rst_n |-> !busy)
        else $error("busy high outside reset");

    a_valid_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, NS + 2))
        else $error("result strobe without an item accepted at the right time");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_pre_vld)
        else $error("pipeline not cleared by reset");

endmodule

`default_nettype wire

// ----- bench/signed_int32_divider_tb.sv -----
`timescale 1ns / 1ps

module signed_int32_divider_tb;

    localparam logic [31:0] INT_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN  = 32'h8000_0000;
    localparam logic [31:0] ZDIV_NEG = 32'h8000_0001;  // zero divisor, negative dividend
    localparam int          NUM_DIRECTED  = 23;
    localparam int          ITEMS_PER_PHASE = 567;
    localparam int          DRAIN_CYCLES  = 24;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        has_q;  // quotient typed in below, else predicted
        logic [31:0] q;
    } t_div_case;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_numerator = '0;
    logic signed [31:0] i_denominator = '0;
    logic               o_valid;
    logic signed [31:0] o_quotient;

    // typed-in quotient that travels with the item on the bus
    logic               cur_has_q = 1'b0;
    logic [31:0]        cur_q = '0;

    logic [31:0]        quot_expected_q [$];
    logic [31:0]        quot_exp;
    int unsigned        err_count = 0;
    t_div_case          directed_cases [NUM_DIRECTED];

    signed_int32_divider dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_numerator   (i_numerator),
        .i_denominator (i_denominator),
        .o_valid       (o_valid),
        .o_quotient    (o_quotient)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] predict_quotient(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] mag_q;
        if (b == '0) begin
            if (a == '0)
                return '0;
            return a[31] ? ZDIV_NEG : INT_MAX;
        end
        mag_a = a[31] ? -a : a;
        mag_b = b[31] ? -b : b;
        mag_q = mag_a / mag_b;
        if (a[31] != b[31])
            return -mag_q;
        // only INT_MIN / -1 lands here
        if (mag_q > INT_MAX)
            return INT_MAX;
        return mag_q;
    endfunction

    function automatic logic [31:0] pick_operand(input bit for_den);
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1, 2: v = $urandom();
            3:       v = $urandom() >> $urandom_range(31);
            4:       v = -($urandom() >> $urandom_range(31));
            5:       v = $urandom_range(200) - 100;
            6: begin
                case ($urandom_range(4))
                    0:       v = INT_MIN;
                    1:       v = INT_MAX;
                    2:       v = '0;
                    3:       v = 32'd1;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            7:       v = for_den ? '0 : $urandom();
            default: v = $urandom() | INT_MIN;
        endcase
        return v;
    endfunction

    task automatic send_div(input logic [31:0] num, input logic [31:0] den,
                            input logic has_q, input logic [31:0] q, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_numerator   <= num;
        i_denominator <= den;
        cur_has_q     <= has_q;
        cur_q         <= q;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    // result check first, then record the item accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (quot_expected_q.size() == 0) begin
                    $error("quotient: expected none, actual %0d", o_quotient);
                    err_count++;
                end else begin
                    quot_exp = quot_expected_q.pop_front();
                    if (o_quotient !== quot_exp) begin
                        $error("quotient: expected %0d, actual %0d",
                               $signed(quot_exp), o_quotient);
                        err_count++;
                    end
                end
            end
            if (start && !busy)
                quot_expected_q.push_back(cur_has_q ? cur_q
                                                    : predict_quotient(i_numerator, i_denominator));
        end
    end

    initial begin
        int          idle_pct;
        logic [31:0] num;
        logic [31:0] den;
        directed_cases = '{
            '{INT_MIN,        32'hFFFF_FFFF, 1'b1, INT_MAX},        // overflow saturates
            '{INT_MIN,        32'd1,         1'b1, INT_MIN},
            '{INT_MAX,        32'd1,         1'b1, INT_MAX},
            '{INT_MAX,        32'hFFFF_FFFF, 1'b1, ZDIV_NEG},
            '{32'd5,          32'd0,         1'b1, INT_MAX},
            '{-32'sd5,        32'd0,         1'b1, ZDIV_NEG},
            '{INT_MIN,        32'd0,         1'b1, ZDIV_NEG},
            '{INT_MAX,        32'd0,         1'b1, INT_MAX},
            '{32'd0,          32'd0,         1'b1, 32'd0},
            '{32'd0,          INT_MIN,       1'b1, 32'd0},
            '{INT_MIN,        INT_MIN,       1'b1, 32'd1},
            '{INT_MAX,        INT_MIN,       1'b1, 32'd0},
            '{32'hFFFF_FFFF,  INT_MIN,       1'b1, 32'd0},
            '{INT_MIN,        INT_MAX,       1'b1, 32'hFFFF_FFFF},
            '{32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 32'd1},
            '{INT_MAX,        INT_MAX,       1'b1, 32'd1},
            '{32'd7,          32'd2,         1'b0, 32'd0},
            '{-32'sd7,        32'd2,         1'b0, 32'd0},
            '{32'd7,          -32'sd2,       1'b0, 32'd0},
            '{-32'sd7,        -32'sd2,       1'b0, 32'd0},
            '{32'd5,          32'd7,         1'b0, 32'd0},
            '{32'h5555_5555,  32'd3,         1'b0, 32'd0},
            '{32'hAAAA_AAAA,  32'h0001_0000, 1'b0, 32'd0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_div(directed_cases[i].num, directed_cases[i].den,
                     directed_cases[i].has_q, directed_cases[i].q, 31);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 31 : (phase == 1) ? 62 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                den = pick_operand(1'b1);
                num = pick_operand(1'b0);
                // near-exact multiples exercise the remainder boundary
                if ($urandom_range(7) == 0)
                    num = den * ($urandom_range(2000) - 1000) + ($urandom_range(6) - 3);
                send_div(num, den, 1'b0, '0, idle_pct);
            end
        end
        start <= 1'b0;

        while (quot_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("signed_int32_divider_tb: done, clean");
        else
            $display("signed_int32_divider_tb: done, errors");
        $finish;
    end

    initial begin
        #400000;
        $display("signed_int32_divider_tb: done, errors");
        $finish;
    end

endmodule
